// ----- hw/rtl/sxf_pkg.sv -----
`timescale 1ns / 1ps

package sxf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 32;

    localparam int ROW_BITS    = 64;
    localparam int MAX_ROW_W   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic                 hit;
        logic [MAX_ROW_W-1:0] row;
        logic [ROW_BITS-1:0]  mask;
        logic                 last;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic acc;
    } back_stat_t;

endpackage

// ----- hw/rtl/sxf_ram.sv -----
`timescale 1ns / 1ps

module sxf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/sxf_queue.sv -----
`timescale 1ns / 1ps

module sxf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sxf_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sxf_pkg::entry_t head_entry
);

    sxf_pkg::entry_t slot_reg [sxf_pkg::QUEUE_DEPTH];

    logic [sxf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sxf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sxf_pkg::QPTR_W:0]   count_reg, count_next;

    localparam logic [sxf_pkg::QPTR_W:0] DEPTH_CNT = (sxf_pkg::QPTR_W + 1)'(sxf_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/sxf_front.sv -----
`timescale 1ns / 1ps

module sxf_front #(
    parameter int SCREEN_WIDTH  = sxf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = sxf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic [1:0]      action,
    input  logic [5:0]      x_pos,
    input  logic [4:0]      y_pos,
    input  logic [3:0]      row_offset,
    input  logic [7:0]      sprite_byte,
    input  logic            last_row,
    output sxf_pkg::entry_t entry
);

    localparam logic [6:0] W7       = 7'(SCREEN_WIDTH);
    localparam logic [6:0] H7       = 7'(SCREEN_HEIGHT);
    localparam logic [5:0] LAST_COL = 6'd63;

    logic [5:0] sx;
    logic [4:0] sy;
    logic [6:0] row_sum;
    logic [6:0] col;
    logic [sxf_pkg::ROW_BITS-1:0] mask;

    always_comb
    begin
        sx = x_pos;
        for (int i = 0; i < 8; i++)
        begin
            if ({1'b0, sx} >= W7)
            begin
                sx = sx - W7[5:0];
            end
        end
        sy = y_pos;
        for (int i = 0; i < 4; i++)
        begin
            if ({2'b00, sy} >= H7)
            begin
                sy = sy - H7[4:0];
            end
        end
        row_sum = {2'b00, sy} + {3'b000, row_offset};
        mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            col = {1'b0, sx} + 7'(i);
            if (sprite_byte[7-i] && (col < W7))
            begin
                mask[LAST_COL - col[5:0]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        entry.op   = action;
        entry.mask = mask;
        entry.last = last_row;
        if (action == sxf_pkg::ACT_READ)
        begin
            entry.hit = ({2'b00, y_pos} < H7);
            entry.row = {1'b0, y_pos};
        end
        else
        begin
            entry.hit = (row_sum < H7);
            entry.row = row_sum[5:0];
        end
    end

endmodule

// ----- hw/rtl/sxf_back.sv -----
`timescale 1ns / 1ps

module sxf_back #(
    parameter int SCREEN_HEIGHT = sxf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  sxf_pkg::entry_t              head_entry,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         collision,
    output logic [sxf_pkg::ROW_BITS-1:0] pixel_row,
    output logic                         sprite_done,
    output sxf_pkg::back_stat_t          stat
);

    localparam int RW = $clog2(SCREEN_HEIGHT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WB   = 1'b1;

    logic st_reg, st_next;
    logic acc_reg, acc_next;
    logic [SCREEN_HEIGHT-1:0] valid_reg, valid_next;
    sxf_pkg::entry_t cur_reg, cur_next;

    logic out_valid_reg, out_valid_next;
    logic collision_reg, collision_next;
    logic sprite_done_reg, sprite_done_next;
    logic [sxf_pkg::ROW_BITS-1:0] pixel_row_reg, pixel_row_next;

    logic rd_en;
    logic wr_en;
    logic [sxf_pkg::ROW_BITS-1:0] ram_q;
    logic [sxf_pkg::ROW_BITS-1:0] row_data;
    logic [sxf_pkg::ROW_BITS-1:0] wr_data;
    logic coll_now;

    assign pop = (st_reg == ST_IDLE) && head_valid && (!out_valid_reg || out_ready);

    assign row_data = valid_reg[cur_reg.row[RW-1:0]] ? ram_q : '0;
    assign coll_now = acc_reg | (|(row_data & cur_reg.mask));
    assign wr_data  = row_data ^ cur_reg.mask;

    always_comb
    begin
        st_next          = st_reg;
        acc_next         = acc_reg;
        valid_next       = valid_reg;
        cur_next         = cur_reg;
        out_valid_next   = out_valid_reg;
        collision_next   = collision_reg;
        sprite_done_next = sprite_done_reg;
        pixel_row_next   = pixel_row_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_next = head_entry;
                    if (head_entry.hit && (head_entry.op == sxf_pkg::ACT_DRAW ||
                                           head_entry.op == sxf_pkg::ACT_READ))
                    begin
                        rd_en   = 1'b1;
                        st_next = ST_WB;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        collision_next   = 1'b0;
                        sprite_done_next = 1'b0;
                        pixel_row_next   = '0;
                        unique case (head_entry.op)
                            sxf_pkg::ACT_DRAW:
                            begin
                                collision_next   = acc_reg;
                                sprite_done_next = head_entry.last;
                                if (head_entry.last)
                                begin
                                    acc_next = 1'b0;
                                end
                            end
                            sxf_pkg::ACT_CLEAR:
                            begin
                                valid_next = '0;
                            end
                            sxf_pkg::ACT_READ:
                            begin
                            end
                            sxf_pkg::ACT_NONE:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_WB:
            begin
                out_valid_next   = 1'b1;
                collision_next   = 1'b0;
                sprite_done_next = 1'b0;
                pixel_row_next   = '0;
                st_next          = ST_IDLE;
                if (cur_reg.op == sxf_pkg::ACT_DRAW)
                begin
                    wr_en            = 1'b1;
                    valid_next[cur_reg.row[RW-1:0]] = 1'b1;
                    collision_next   = coll_now;
                    sprite_done_next = cur_reg.last;
                    acc_next         = cur_reg.last ? 1'b0 : coll_now;
                end
                else
                begin
                    pixel_row_next = row_data;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            acc_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            acc_reg       <= acc_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        collision_reg   <= collision_next;
        sprite_done_reg <= sprite_done_next;
        pixel_row_reg   <= pixel_row_next;
    end

    sxf_ram #(
        .WIDTH (sxf_pkg::ROW_BITS),
        .DEPTH (SCREEN_HEIGHT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_reg.row[RW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_entry.row[RW-1:0]),
        .rd_data (ram_q)
    );

    assign out_valid   = out_valid_reg;
    assign collision   = collision_reg;
    assign sprite_done = sprite_done_reg;
    assign pixel_row   = pixel_row_reg;
    assign stat.busy   = (st_reg == ST_WB);
    assign stat.acc    = acc_reg;

endmodule

// ----- hw/rtl/sprite_xor_framebuffer.sv -----
`timescale 1ns / 1ps

// Monochrome XOR framebuffer with sprite-row drawing and collision report. Each
// accepted word is classified on entry (start wrap, edge clipping, 64-bit pixel
// mask) and held in a two-word queue, so input is taken while the execution side
// works or the result waits. A draw or in-range row read reads the row from the
// dual-port framebuffer memory with its registered read, then in the write-back
// state a draw XORs the mask back in and writes the row; the result (for a read,
// the row itself) is registered. Clear, off-screen words and unused actions skip
// that state; clear works through one valid flag per row, so no clearing pass
// is needed after reset or clear. One result word per input word, in order.

module sprite_xor_framebuffer #(
    parameter int SCREEN_WIDTH  = sxf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = sxf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [5:0]                   x_pos,
    input  logic [4:0]                   y_pos,
    input  logic [3:0]                   row_offset,
    input  logic [7:0]                   sprite_byte,
    input  logic                         last_row,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         collision,
    output logic [sxf_pkg::ROW_BITS-1:0] pixel_row,
    output logic                         sprite_done
);

    sxf_pkg::entry_t     front_entry;
    sxf_pkg::entry_t     head_entry;
    sxf_pkg::back_stat_t back_stat;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign in_ready = !q_full;

    sxf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .action      (action),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .row_offset  (row_offset),
        .sprite_byte (sprite_byte),
        .last_row    (last_row),
        .entry       (front_entry)
    );

    sxf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    sxf_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_entry  (head_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .collision   (collision),
        .pixel_row   (pixel_row),
        .sprite_done (sprite_done),
        .stat        (back_stat)
    );

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_valid)
        else $error("queue full with no head word");

    a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.busy |-> !out_valid)
        else $error("row update started while result slot occupied");

    a_busy_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.busy |=> out_valid && !back_stat.busy)
        else $error("row update did not produce a result");

    a_done_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && sprite_done |-> !back_stat.acc)
        else $error("collision flag kept after last sprite row");

endmodule

// ----- tb/sv/sprite_xor_framebuffer_tb.sv -----
`timescale 1ns / 1ps

module sprite_xor_framebuffer_tb;

    localparam int FB_W        = 64;
    localparam int FB_H        = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [1:0] action;
        logic [5:0] x_pos;
        logic [4:0] y_pos;
        logic [3:0] row_offset;
        logic [7:0] sprite_byte;
        logic       last_row;
    } sprite_word_t;

    typedef struct {
        logic          collision;
        logic [63:0]   pixel_row;
        logic          sprite_done;
    } row_result_t;

    class frame_scoreboard;
        logic [63:0] screen[FB_H];
        bit          hit_acc;
        row_result_t expected_rows[$];
        int          errors;
        int          draws;
        int          hits;
        int          reads;
        int          clears;
        int          others;
        int          results;

        function new();
            foreach (screen[i])
                screen[i] = '0;
            hit_acc = 1'b0;
            errors  = 0;
            draws   = 0;
            hits    = 0;
            reads   = 0;
            clears  = 0;
            others  = 0;
            results = 0;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        function void note_word(sprite_word_t w);
            row_result_t r;
            logic [63:0] mask;
            int          sx;
            int          row;
            int          col;
            r.collision   = 1'b0;
            r.pixel_row   = '0;
            r.sprite_done = 1'b0;
            case (w.action)
                sxf_pkg::ACT_DRAW:
                begin
                    sx  = int'(w.x_pos) % FB_W;
                    row = (int'(w.y_pos) % FB_H) + int'(w.row_offset);
                    if (row < FB_H)
                    begin
                        mask = '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            col = sx + i;
                            if (w.sprite_byte[7 - i] && col < FB_W)
                                mask[63 - col] = 1'b1;
                        end
                        if ((screen[row] & mask) != '0)
                            hit_acc = 1'b1;
                        screen[row] ^= mask;
                    end
                    r.collision   = hit_acc;
                    r.sprite_done = w.last_row;
                    if (w.last_row)
                        hit_acc = 1'b0;
                    draws++;
                    if (r.collision)
                        hits++;
                end
                sxf_pkg::ACT_CLEAR:
                begin
                    foreach (screen[i])
                        screen[i] = '0;
                    clears++;
                end
                sxf_pkg::ACT_READ:
                begin
                    if (int'(w.y_pos) < FB_H)
                        r.pixel_row = screen[w.y_pos];
                    reads++;
                end
                default:
                    others++;
            endcase
            expected_rows.push_back(r);
        endfunction

        function void check_result(logic c, logic [63:0] p, logic d);
            row_result_t r;
            results++;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result word: collision=%0b pixel_row=%h sprite_done=%0b",
                       c, p, d);
                errors++;
                return;
            end
            r = expected_rows.pop_front();
            if (c !== r.collision)
            begin
                $error("collision: expected %0b, actual %0b", r.collision, c);
                errors++;
            end
            if (p !== r.pixel_row)
            begin
                $error("pixel_row: expected %h, actual %h", r.pixel_row, p);
                errors++;
            end
            if (d !== r.sprite_done)
            begin
                $error("sprite_done: expected %0b, actual %0b", r.sprite_done, d);
                errors++;
            end
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  action      = sxf_pkg::ACT_NONE;
    logic [5:0]  x_pos       = '0;
    logic [4:0]  y_pos       = '0;
    logic [3:0]  row_offset  = '0;
    logic [7:0]  sprite_byte = '0;
    logic        last_row    = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        collision;
    logic [sxf_pkg::ROW_BITS-1:0] pixel_row;
    logic        sprite_done;

    frame_scoreboard sb;
    int          in_idle  = 0;
    int          out_idle = 0;
    int          cycle    = 0;

    sprite_xor_framebuffer #(
        .SCREEN_WIDTH (FB_W),
        .SCREEN_HEIGHT(FB_H)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .row_offset (row_offset),
        .sprite_byte(sprite_byte),
        .last_row   (last_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .collision  (collision),
        .pixel_row  (pixel_row),
        .sprite_done(sprite_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(collision, pixel_row, sprite_done);
            out_ready <= ($urandom_range(99) >= out_idle);
        end
    end

    function automatic sprite_word_t make_word(logic [1:0] a, int x, int y, int off, int b,
                                               int last);
        sprite_word_t w;
        w.action      = a;
        w.x_pos       = x[5:0];
        w.y_pos       = y[4:0];
        w.row_offset  = off[3:0];
        w.sprite_byte = b[7:0];
        w.last_row    = last[0];
        return w;
    endfunction

    task automatic send_word(input sprite_word_t w);
        while ($urandom_range(99) < in_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action      <= w.action;
        x_pos       <= w.x_pos;
        y_pos       <= w.y_pos;
        row_offset  <= w.row_offset;
        sprite_byte <= w.sprite_byte;
        last_row    <= w.last_row;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
    endtask

    // hold off input until every outstanding word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic random_phase(input int count, input int idle_in, input int idle_out);
        int sent;
        int pick;
        int n;
        int x;
        int y;
        in_idle  = idle_in;
        out_idle = idle_out;
        sent     = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5);
                x = ($urandom_range(3) == 0) ? $urandom_range(56, 63) : $urandom_range(63);
                y = $urandom_range(31);
                for (int r = 0; r < n; r++)
                begin
                    send_word(make_word(sxf_pkg::ACT_DRAW, x, y, r, $urandom_range(255),
                                        int'(r == n - 1)));
                    sent++;
                end
            end
            else if (pick < 80)
            begin
                n = $urandom_range(1, 6);
                for (int r = 0; r < n; r++)
                begin
                    send_word(make_word(sxf_pkg::ACT_READ, $urandom_range(63),
                                        $urandom_range(31), $urandom_range(15),
                                        $urandom_range(255), $urandom_range(1)));
                    sent++;
                end
            end
            else if (pick < 84)
            begin
                send_word(make_word(sxf_pkg::ACT_CLEAR, $urandom_range(63),
                                    $urandom_range(31), $urandom_range(15),
                                    $urandom_range(255), $urandom_range(1)));
                sent++;
            end
            else if (pick < 88)
            begin
                send_word(make_word(sxf_pkg::ACT_NONE, $urandom_range(63),
                                    $urandom_range(31), $urandom_range(15),
                                    $urandom_range(255), $urandom_range(1)));
                sent++;
            end
            else if (pick < 98)
            begin
                send_word(make_word(sxf_pkg::ACT_DRAW, $urandom_range(63),
                                    $urandom_range(31), $urandom_range(15),
                                    $urandom_range(255), $urandom_range(1)));
                sent++;
            end
            else
                drain();
        end
        drain();
    endtask

    initial
    begin
        sb       = new();
        in_idle  = 26;
        out_idle = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(sxf_pkg::ACT_DRAW, 0, 0, 0, 8'hFF, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 0, 0, 0, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 0, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 60, 0, 0, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 0, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 63, 3, 0, 8'h80, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 63, 3, 0, 8'h81, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 3, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 0, 31, 15, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_DRAW, 0, 20, 11, 8'hAA, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 7, 31, 0, 8'h55, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 31, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 10, 5, 0, 8'hFF, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 10, 5, 0, 8'h0F, 0));
        send_word(make_word(sxf_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 40, 8, 0, 8'h3C, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 5, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_NONE, 63, 31, 15, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 63, 31, 15, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_CLEAR, 63, 31, 15, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 8, 0, 0, 0));
        send_word(make_word(sxf_pkg::ACT_DRAW, 32, 16, 15, 8'h01, 1));
        send_word(make_word(sxf_pkg::ACT_DRAW, 63, 0, 15, 8'hFF, 1));
        send_word(make_word(sxf_pkg::ACT_READ, 0, 15, 0, 0, 0));
        drain();

        random_phase(275, 26, 50);
        random_phase(275, 50, 26);
        random_phase(275, 0, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d draws (%0d reporting a collision), %0d row reads,",
                 sb.draws, sb.hits, sb.reads);
        $display("%0d clears and %0d unused-action words; %0d results checked.",
                 sb.clears, sb.others, sb.results);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
